// ===== hdl/dlc_pkg.sv =====
// Shared types, constants and codes of the door lock controller.
package dlc_pkg;

  // Password length default and command characters
  localparam int unsigned PASSWORD_LENGTH = 4;
  localparam logic [7:0]  CMD_OPEN        = 8'h2B;  // '+'
  localparam logic [7:0]  CMD_CHANGE      = 8'h2D;  // '-'

  // Reset values of the configuration registers
  localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd30;
  localparam logic [7:0] UNLOCK_SECONDS_RST   = 8'd15;
  localparam logic [7:0] HOLD_SECONDS_RST     = 8'd18;
  localparam logic [7:0] RELOCK_SECONDS_RST   = 8'd33;
  localparam logic [7:0] ALARM_SECONDS_RST    = 8'd60;
  localparam logic [2:0] MAX_ATTEMPTS_RST     = 3'd3;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TICKS_PER_SECOND = 3'd0,
    REG_UNLOCK_SECONDS   = 3'd1,
    REG_HOLD_SECONDS     = 3'd2,
    REG_RELOCK_SECONDS   = 3'd3,
    REG_ALARM_SECONDS    = 3'd4,
    REG_MAX_ATTEMPTS     = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MOTOR_OFF = 2'd0,
    MOTOR_CW  = 2'd1,
    MOTOR_CCW = 2'd2
  } motor_e;

  typedef enum logic [8:0] {
    PH_FIRST  = 9'b000000001,
    PH_SECOND = 9'b000000010,
    PH_IDLE   = 9'b000000100,
    PH_CHECK  = 9'b000001000,
    PH_UNLOCK = 9'b000010000,
    PH_HOLD   = 9'b000100000,
    PH_RELOCK = 9'b001000000,
    PH_ALARM  = 9'b010000000,
    PH_HALTED = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [7:0] unlock_seconds;
    logic [7:0] hold_seconds;
    logic [7:0] relock_seconds;
    logic [7:0] alarm_seconds;
    logic [2:0] max_attempts;
  } cfg_t;

  // Classified item as handed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_open;
    logic       is_change;
    logic [7:0] data;
  } item_t;

  // Result word, lowest bit first: reply_valid, reply_match, motor_drive,
  // buzzer_on, lock_halted, zero fill
  typedef struct packed {
    logic [1:0] pad;
    logic       lock_halted;
    logic       buzzer_on;
    logic [1:0] motor_drive;
    logic       reply_match;
    logic       reply_valid;
  } result_t;

endpackage

// ===== hdl/dlc_front.sv =====
// Front end: takes input items, decodes command bytes, queues them for the back end.
module dlc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_tick_i,
  input  logic [7:0]     in_data_i,
  output logic           item_valid_o,
  input  logic           item_ready_i,
  output dlc_pkg::item_t item_o
);
  import dlc_pkg::*;

  item_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] count_q;
  item_t                  item_new;
  logic                   push, pop;

  always_comb begin
    item_new.is_tick   = in_tick_i;
    item_new.is_open   = !in_tick_i && (in_data_i == CMD_OPEN);
    item_new.is_change = !in_tick_i && (in_data_i == CMD_CHANGE);
    item_new.data      = in_data_i;
  end

  assign in_ready_o   = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/dlc_back.sv =====
// Back end: lock state machine, password stores, timers and the result register.
module dlc_back #(
  parameter int unsigned PasswordLength = dlc_pkg::PASSWORD_LENGTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dlc_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  dlc_pkg::item_t   item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output dlc_pkg::result_t res_o
);
  import dlc_pkg::*;

  localparam int unsigned IdxW = (PasswordLength > 1) ? $clog2(PasswordLength) : 1;

  phase_e          phase_q, phase_d;
  logic [7:0]      saved_q [PasswordLength];
  logic [7:0]      first_q [PasswordLength];
  logic            mism_q, mism_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [2:0]      att_q, att_d;
  logic [7:0]      tick_q, tick_d;
  logic [7:0]      sec_q, sec_d;
  logic            res_valid_q;
  result_t         res_q, res_d;

  logic            take, first_wr, save_copy, last, mis_new;
  logic [7:0]      tick_inc, ref_byte;
  logic [2:0]      att_inc;
  phase_e          ph_step;

  assign item_ready_o = !res_valid_q || res_ready_i;
  assign take         = item_valid_i && item_ready_o;

  always_comb begin
    ref_byte = (phase_q == PH_SECOND) ? first_q[idx_q] : saved_q[idx_q];
    mis_new  = ((idx_q == '0) ? 1'b0 : mism_q) ||
               ((phase_q != PH_FIRST) && (ref_byte != item_i.data));
    last     = (idx_q == IdxW'(PasswordLength - 1));
    tick_inc = tick_q + 8'd1;
    att_inc  = att_q + 3'd1;
  end

  always_comb begin
    ph_step   = phase_q;
    phase_d   = phase_q;
    mism_d    = mism_q;
    idx_d     = idx_q;
    att_d     = att_q;
    tick_d    = tick_q;
    sec_d     = sec_q;
    first_wr  = 1'b0;
    save_copy = 1'b0;
    res_d     = '0;
    if (take && phase_q != PH_HALTED) begin
      if (item_i.is_tick) begin
        if (tick_inc == cfg_i.ticks_per_second) begin
          tick_d = '0;
          if (sec_q != 8'd255) sec_d = sec_q + 8'd1;
        end else begin
          tick_d = tick_inc;
        end
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (item_i.is_change) begin
              ph_step = PH_FIRST;
              idx_d   = '0;
            end else if (item_i.is_open) begin
              ph_step = PH_CHECK;
              idx_d   = '0;
              mism_d  = 1'b0;
              att_d   = '0;
            end
          end
          PH_FIRST, PH_SECOND, PH_CHECK: begin
            first_wr = (phase_q == PH_FIRST);
            mism_d   = mis_new;
            idx_d    = last ? '0 : idx_q + 1'b1;
            if (last) begin
              if (phase_q == PH_FIRST) begin
                ph_step = PH_SECOND;
              end else begin
                res_d.reply_valid = 1'b1;
                res_d.reply_match = !mis_new;
                if (phase_q == PH_SECOND) begin
                  save_copy = !mis_new;
                  ph_step   = mis_new ? PH_FIRST : PH_IDLE;
                end else if (!mis_new) begin
                  ph_step = PH_UNLOCK;
                  sec_d   = '0;
                end else begin
                  att_d = att_inc;
                  if (att_inc >= cfg_i.max_attempts || att_inc == '0) begin
                    ph_step = PH_ALARM;
                    sec_d   = '0;
                  end
                end
              end
            end
          end
          default: ;
        endcase
      end
      // several expired phases may end in one step
      phase_d = ph_step;
      if (phase_d == PH_UNLOCK && sec_d > cfg_i.unlock_seconds) phase_d = PH_HOLD;
      if (phase_d == PH_HOLD   && sec_d > cfg_i.hold_seconds)   phase_d = PH_RELOCK;
      if (phase_d == PH_RELOCK && sec_d > cfg_i.relock_seconds) phase_d = PH_IDLE;
      if (phase_d == PH_ALARM  && sec_d > cfg_i.alarm_seconds)  phase_d = PH_HALTED;
    end
    res_d.motor_drive = (phase_d == PH_UNLOCK) ? MOTOR_CW  :
                        (phase_d == PH_RELOCK) ? MOTOR_CCW : MOTOR_OFF;
    res_d.buzzer_on   = (phase_d == PH_ALARM);
    res_d.lock_halted = (phase_d == PH_HALTED);
  end

  always_ff @(posedge clk_i) begin
    if (first_wr) first_q[idx_q] <= item_i.data;
    if (save_copy) begin
      for (int k = 0; k < PasswordLength; k++) saved_q[k] <= first_q[k];
    end
    if (take) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      mism_q      <= 1'b0;
      idx_q       <= '0;
      att_q       <= '0;
      tick_q      <= '0;
      sec_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      mism_q  <= mism_d;
      idx_q   <= idx_d;
      att_q   <= att_d;
      tick_q  <= tick_d;
      sec_q   <= sec_d;
      if (take) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/password_door_lock_controller_top.sv =====
// Top level of the password door lock controller: config registers, front, back.
//
// Input stream (s_axis): one item is a received byte (tuser = 0, tdata = the
// byte) or a timer tick (tuser = 1, tdata ignored). Every accepted item gives
// exactly one result item on m_axis: reply_valid/reply_match for a finished
// password entry, plus the motor drive, buzzer and halted flags as they stand
// after that item.
// Config port: cfg_index_i selects ticks_per_second, unlock_seconds,
// hold_seconds, relock_seconds, alarm_seconds, max_attempts (0..5); other
// indexes are dropped. cfg_ready_o is always high. Write only while idle.
// Throughput: one item per cycle while m_axis is ready. The front decodes each
// item into a two-entry queue; the back pops one item per cycle into the result
// register, so an item passes through the queue and then the result register.
// Receiver stall: the result register holds, the back stops popping, the
// queue fills and s_axis_tready_o drops once both entries are taken.
// Reset: phase goes to first password entry, counters clear, config registers
// take their defaults; the stored password is undefined until first setup.
module password_door_lock_controller_top #(
  parameter int unsigned PasswordLength = dlc_pkg::PASSWORD_LENGTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input items
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] action (0 byte, 1 tick)
  // result items
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] reply_valid, [1] reply_match,
                                       // [3:2] motor_drive, [4] buzzer_on,
                                       // [5] lock_halted, [7:6] zero
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import dlc_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_ready;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second <= TICKS_PER_SECOND_RST;
      cfg_q.unlock_seconds   <= UNLOCK_SECONDS_RST;
      cfg_q.hold_seconds     <= HOLD_SECONDS_RST;
      cfg_q.relock_seconds   <= RELOCK_SECONDS_RST;
      cfg_q.alarm_seconds    <= ALARM_SECONDS_RST;
      cfg_q.max_attempts     <= MAX_ATTEMPTS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_data_i;
        REG_UNLOCK_SECONDS:   cfg_q.unlock_seconds   <= cfg_data_i;
        REG_HOLD_SECONDS:     cfg_q.hold_seconds     <= cfg_data_i;
        REG_RELOCK_SECONDS:   cfg_q.relock_seconds   <= cfg_data_i;
        REG_ALARM_SECONDS:    cfg_q.alarm_seconds    <= cfg_data_i;
        REG_MAX_ATTEMPTS:     cfg_q.max_attempts     <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  dlc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_tick_i    (s_axis_tuser_i),
    .in_data_i    (s_axis_tdata_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  dlc_back #(
    .PasswordLength (PasswordLength)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  assign m_axis_tdata_o = res;

  // a match flag without a reply would be a decode slip
  a_match_needs_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !res.reply_valid |-> !res.reply_match)
    else $error("reply_match set without reply_valid");

  // motor, buzzer and halt belong to separate phases
  a_outputs_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $countones({res.motor_drive != MOTOR_OFF, res.buzzer_on,
                                    res.lock_halted}) <= 1)
    else $error("motor, buzzer and halted flags overlap");

  // once halted, every later result stays halted
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.lock_halted && m_axis_tready_i ##1 m_axis_tvalid_o
    |-> res.lock_halted)
    else $error("left the halted state");

endmodule
